FILE: src/multilevel_priority_fifo_top_defines.svh
// ----------------------------------------------------------------------------
// Multilevel priority FIFO assertion macros
// Shared concurrent assertion wrappers for the multilevel priority FIFO.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_PRIORITY_FIFO_TOP_DEFINES_SVH
`define MULTILEVEL_PRIORITY_FIFO_TOP_DEFINES_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define MLPQ_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion on the block clock and reset.
`define MLPQ_ASSERT(lbl, prop, msg) \
  `MLPQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: src/mlpq_pkg.sv
// ----------------------------------------------------------------------------
// Multilevel priority FIFO package
// Payload types, operation codes and state codes shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlpq_pkg;

  localparam int NUM_LEVELS_DEF  = 8;
  localparam int LEVEL_DEPTH_DEF = 16;
  localparam int ID_WIDTH_DEF    = 16;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_PEEK = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LVL,
    ST_RD,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] task_id;
    logic [3:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic [15:0] served_task;
    logic        served_valid;
    logic [3:0]  served_level;
    logic [4:0]  level_count;
    logic [7:0]  total_count;
    logic        all_empty;
    logic        push_dropped;
  } out_item_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } store_cmd_t;

endpackage

FILE: src/mlpq_store.sv
// ----------------------------------------------------------------------------
// Multilevel priority FIFO task store
// Single-port-write, single-port-read synchronous memory holding the task
// ids of all levels, addressed by level and slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlpq_store
  import mlpq_pkg::*;
#(
  parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  parameter int ID_WIDTH    = ID_WIDTH_DEF,
  localparam int LW = $clog2(NUM_LEVELS),
  localparam int PW = $clog2(LEVEL_DEPTH)
) (
  input  logic                clk_i,
  input  store_cmd_t          cmd_i,
  input  logic [LW-1:0]       lv_i,
  input  logic [PW-1:0]       idx_i,
  input  logic [ID_WIDTH-1:0] wdata_i,
  output logic [ID_WIDTH-1:0] rdata_o
);

  localparam int Size = NUM_LEVELS * LEVEL_DEPTH;
  localparam int AW   = $clog2(Size);

  logic [ID_WIDTH-1:0] mem [Size];
  logic [AW-1:0]       addr;
  logic [ID_WIDTH-1:0] rdata_q;

  assign addr = AW'(lv_i) * AW'(LEVEL_DEPTH) + AW'(idx_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[addr] <= wdata_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/multilevel_priority_fifo_top.sv
// ----------------------------------------------------------------------------
// Multilevel priority FIFO
// Per-level task FIFOs with highest-level-first service.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i, in_ready_o, in_data_i) takes one
// request (push, pop or peek); the output channel (out_valid_o, out_ready_i,
// out_data_o) returns one result for every request, in order.
// Per-level head, tail and fill live in a level-state memory; task ids live
// in a task store. Both are read through a registered read port.
// Result path: a push or a request that serves no task is answered from the
// level-state lookup; a pop or peek that returns a task is answered after
// the task store read (level-state read, then task store read).
// The block takes a new request only once the previous result has entered
// the output register; the serial level-state and task store reads pace it.
// Reset clears the level-state valid bits, the non-empty flags and the total
// count at once; the task store needs no clearing, so reset adds no pass.
// When the receiver stalls, the output register holds its result; the block
// still takes one more request and parks its finished result until the
// output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multilevel_priority_fifo_top_defines.svh"

module multilevel_priority_fifo_top
  import mlpq_pkg::*;
#(
  parameter int NUM_LEVELS  = NUM_LEVELS_DEF,
  parameter int LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int LW = $clog2(NUM_LEVELS);
  localparam int PW = $clog2(LEVEL_DEPTH);
  localparam int FW = $clog2(LEVEL_DEPTH + 1);
  localparam int TW = $clog2(NUM_LEVELS * LEVEL_DEPTH + 1);
  localparam int EW = 2 * PW + FW;

  state_e state_q, state_d;

  in_item_t  item_q;
  logic [LW-1:0] op_lv_q;
  logic          any_q;

  logic [EW-1:0] lvl_mem [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] lvl_vld_q;
  logic [EW-1:0] a_rd_q, b_rd_q;
  logic          a_vld_q, b_vld_q;

  logic [NUM_LEVELS-1:0] ne_q, ne_d;
  logic [TW-1:0] total_q, total_d;

  out_item_t res_q, res_d, res_lvl;
  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free;

  logic          accept;
  logic [31:0]   in_prio_m1;
  logic [LW-1:0] in_lv;
  logic [LW-1:0] top_lv;
  logic          any_ne;

  logic [EW-1:0] ent_a, ent_b;
  logic [PW-1:0] head_a, tail_a;
  logic [FW-1:0] fill_a, fill_b, fill_new;
  logic [PW-1:0] head_new, tail_new;
  logic [LW-1:0] lv_b;
  logic [31:0]   item_prio_m1;
  logic          prio_ok;
  logic          lvl_we;
  logic [EW-1:0] lvl_wdata;

  store_cmd_t          store_cmd;
  logic [PW-1:0]       store_idx;
  logic [31:0]         task_ext;
  logic [ID_WIDTH-1:0] store_rdata;
  logic [31:0]         rd_ext;
  logic [31:0]         lvl_ext;
  logic [31:0]         cnt_ext;
  logic [31:0]         tot_ext;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] idx);
    return (idx == PW'(LEVEL_DEPTH - 1)) ? '0 : idx + PW'(1);
  endfunction

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  assign in_prio_m1 = 32'(in_data_i.priority_req) - 32'd1;
  assign in_lv      = in_prio_m1[LW-1:0];

  always_comb begin
    top_lv = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (ne_q[i]) begin
        top_lv = LW'(i);
      end
    end
  end

  assign any_ne = |ne_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q  <= in_data_i;
      op_lv_q <= (in_data_i.kind == KIND_PUSH) ? in_lv : top_lv;
      any_q   <= any_ne;
      a_rd_q  <= lvl_mem[(in_data_i.kind == KIND_PUSH) ? in_lv : top_lv];
      a_vld_q <= lvl_vld_q[(in_data_i.kind == KIND_PUSH) ? in_lv : top_lv];
      b_rd_q  <= lvl_mem[in_lv];
      b_vld_q <= lvl_vld_q[in_lv];
    end
    if (lvl_we) begin
      lvl_mem[op_lv_q] <= lvl_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_vld_q <= '0;
    end else if (lvl_we) begin
      lvl_vld_q[op_lv_q] <= 1'b1;
    end
  end

  assign ent_a  = a_vld_q ? a_rd_q : '0;
  assign ent_b  = b_vld_q ? b_rd_q : '0;
  assign head_a = ent_a[EW-1 -: PW];
  assign tail_a = ent_a[FW+PW-1 -: PW];
  assign fill_a = ent_a[FW-1:0];
  assign fill_b = ent_b[FW-1:0];

  assign item_prio_m1 = 32'(item_q.priority_req) - 32'd1;
  assign lv_b         = item_prio_m1[LW-1:0];
  assign prio_ok      = (item_q.priority_req != 4'd0) &&
                        (32'(item_q.priority_req) <= 32'(NUM_LEVELS));

  assign task_ext = 32'(item_q.task_id);

  mlpq_store #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .cmd_i   (store_cmd),
    .lv_i    (op_lv_q),
    .idx_i   (store_idx),
    .wdata_i (task_ext[ID_WIDTH-1:0]),
    .rdata_o (store_rdata)
  );

  assign rd_ext = 32'(store_rdata);

  always_comb begin
    store_cmd = '0;
    store_idx = head_a;
    lvl_we    = 1'b0;
    head_new  = head_a;
    tail_new  = tail_a;
    fill_new  = fill_a;
    total_d   = total_q;
    ne_d      = ne_q;
    res_lvl   = '0;

    if (state_q == ST_LVL) begin
      case (item_q.kind) inside
        KIND_PUSH: begin
          if (!prio_ok || fill_a == FW'(LEVEL_DEPTH)) begin
            res_lvl.push_dropped = 1'b1;
          end else begin
            store_cmd.wr = 1'b1;
            store_idx    = tail_a;
            tail_new     = next_slot(tail_a);
            fill_new     = fill_a + FW'(1);
            total_d      = total_q + TW'(1);
            lvl_we       = 1'b1;
          end
        end
        KIND_POP, KIND_PEEK: begin
          if (any_q) begin
            store_cmd.rd         = 1'b1;
            res_lvl.served_valid = 1'b1;
            res_lvl.served_level = lvl_ext[3:0];
            if (item_q.kind == KIND_POP) begin
              head_new = next_slot(head_a);
              fill_new = fill_a - FW'(1);
              total_d  = total_q - TW'(1);
              lvl_we   = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      if (lvl_we) begin
        ne_d[op_lv_q] = (fill_new != '0);
      end
      res_lvl.level_count = cnt_ext[4:0];
      res_lvl.total_count = tot_ext[7:0];
      res_lvl.all_empty   = (total_d == '0);
    end
  end

  assign lvl_ext   = 32'(op_lv_q) + 32'd1;
  assign cnt_ext   = !prio_ok ? 32'd0 :
                     (lvl_we && op_lv_q == lv_b) ? 32'(fill_new) : 32'(fill_b);
  assign tot_ext   = 32'(total_d);
  assign lvl_wdata = {head_new, tail_new, fill_new};

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LVL;
        end
      end
      ST_LVL: begin
        res_d = res_lvl;
        if (store_cmd.rd) begin
          state_d = ST_RD;
        end else if (out_free) begin
          out_d       = res_lvl;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_RD: begin
        res_d.served_task = rd_ext[15:0];
        if (out_free) begin
          out_d       = res_d;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ne_q        <= '0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ne_q        <= ne_d;
      total_q     <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MLPQ_ASSERT(a_accept_to_lvl, accept |=> (state_q == ST_LVL), "Transfer did not start a lookup")
  `MLPQ_ASSERT(a_rd_nonempty, store_cmd.rd |-> ne_q[op_lv_q], "Task read from an empty level")
  `MLPQ_ASSERT(a_total_vs_ne, (total_q == '0) == (ne_q == '0), "Total count and level flags disagree")
  `MLPQ_ASSERT(a_drop_no_write, res_lvl.push_dropped |-> !lvl_we && !store_cmd.wr, "Dropped push changed state")

endmodule

FILE: bench/tb_multilevel_priority_fifo_top.sv
// ----------------------------------------------------------------------------
// Multilevel priority FIFO testbench
// Sends push, pop and peek requests to the block over a valid/ready channel
// and checks every returned result against a queue-based prediction of the
// per-level task FIFOs. Both channels see random gaps and one long receiver
// hold-off that backs the block up against its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multilevel_priority_fifo_top;
  import mlpq_pkg::*;

  localparam int          NUM_LVL     = NUM_LEVELS_DEF;
  localparam int          LVL_DEPTH   = LEVEL_DEPTH_DEF;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          HOLD_CYCLES = 300;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;

  class mlpq_scoreboard;
    logic [15:0] level_q[NUM_LVL][$];
    int          total_fill;
    out_item_t   owed_replies[$];
    int          mismatches;
    int          replies_seen;

    function out_item_t serve_request(in_item_t req);
      out_item_t rsp;
      int        top;
      bit        prio_ok;
      rsp     = '0;
      top     = -1;
      prio_ok = (req.priority_req >= 1) && (req.priority_req <= NUM_LVL);
      case (req.kind)
        KIND_PUSH: begin
          if (!prio_ok || level_q[req.priority_req - 1].size() >= LVL_DEPTH) begin
            rsp.push_dropped = 1'b1;
          end else begin
            level_q[req.priority_req - 1].push_back(req.task_id);
            total_fill++;
          end
        end
        KIND_POP, KIND_PEEK: begin
          for (int lv = NUM_LVL - 1; lv >= 0; lv--) begin
            if (top < 0 && level_q[lv].size() != 0) top = lv;
          end
          if (top >= 0) begin
            rsp.served_task  = level_q[top][0];
            rsp.served_valid = 1'b1;
            rsp.served_level = 4'(top + 1);
            if (req.kind == KIND_POP) begin
              void'(level_q[top].pop_front());
              total_fill--;
            end
          end
        end
        default: ;
      endcase
      if (prio_ok) rsp.level_count = 5'(level_q[req.priority_req - 1].size());
      rsp.total_count = 8'(total_fill);
      rsp.all_empty   = (total_fill == 0);
      return rsp;
    endfunction

    function void note_request(in_item_t req);
      owed_replies.push_back(serve_request(req));
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      replies_seen++;
      if (owed_replies.size() == 0) begin
        $error("result with no request outstanding: 0x%0h", got);
        mismatches++;
        return;
      end
      want = owed_replies.pop_front();
      compare_field("served_task", want.served_task, got.served_task);
      compare_field("served_valid", want.served_valid, got.served_valid);
      compare_field("served_level", want.served_level, got.served_level);
      compare_field("level_count", want.level_count, got.level_count);
      compare_field("total_count", want.total_count, got.total_count);
      compare_field("all_empty", want.all_empty, got.all_empty);
      compare_field("push_dropped", want.push_dropped, got.push_dropped);
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_r = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_r = '0;
  logic      out_valid_o;
  logic      out_ready_r = 1'b0;
  out_item_t out_data_o;

  mlpq_scoreboard sb = new();
  int             cycle_count = 0;
  bit             long_hold_done = 1'b0;

  multilevel_priority_fifo_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_r),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_r),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_r),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_r && in_ready_o) sb.note_request(in_data_r);
      if (out_valid_o && out_ready_r) sb.check_result(out_data_o);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_item_t make_request(logic [1:0] kind, int unsigned tid, int prio);
    in_item_t req;
    req.kind         = kind;
    req.task_id      = 16'(tid);
    req.priority_req = 4'(prio);
    return req;
  endfunction

  function automatic in_item_t pick_request(int push_pct, int pop_pct, int lo, int hi);
    int r;
    int s;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 99);
    if (r < 4) return make_request(KIND_UNUSED, $urandom, $urandom_range(0, 15));
    if (r < 9) begin
      return make_request(KIND_PUSH, $urandom,
                          (s < 40) ? 0 : $urandom_range(NUM_LVL + 1, 15));
    end
    if (s < push_pct) return make_request(KIND_PUSH, $urandom, $urandom_range(lo, hi));
    if (s < push_pct + pop_pct) return make_request(KIND_POP, $urandom, $urandom_range(lo, hi));
    return make_request(KIND_PEEK, $urandom, $urandom_range(lo, hi));
  endfunction

  task automatic send_request(input in_item_t req, input int gap);
    if (gap > 0) begin
      in_valid_r <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_r <= 1'b1;
    in_data_r  <= req;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_drained();
    in_valid_r <= 1'b0;
    @(posedge clk_i);
    while (sb.owed_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int n, int push_pct, int pop_pct, int lo, int hi, bit idle);
    for (int i = 0; i < n; i++) begin
      send_request(pick_request(push_pct, pop_pct, lo, hi), idle ? pick_gap() : 0);
    end
    wait_drained();
  endtask

  initial begin
    int run;
    int gap;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      out_ready_r <= 1'b1;
      repeat (run) @(posedge clk_i);
      if (!long_hold_done && sb.replies_seen >= 60) begin
        long_hold_done = 1'b1;
        out_ready_r <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready_r <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    in_item_t directed[$];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    directed.push_back(make_request(KIND_PEEK, 16'h1234, 1));
    directed.push_back(make_request(KIND_POP, 16'h0000, 8));
    directed.push_back(make_request(KIND_UNUSED, 16'hffff, 15));
    directed.push_back(make_request(KIND_PUSH, 16'hbeef, 0));
    directed.push_back(make_request(KIND_PUSH, 16'hffff, 15));
    directed.push_back(make_request(KIND_PUSH, 16'h5a5a, NUM_LVL + 1));
    directed.push_back(make_request(KIND_PUSH, 16'h0000, 1));
    directed.push_back(make_request(KIND_PUSH, 16'hffff, NUM_LVL));
    directed.push_back(make_request(KIND_PUSH, 16'ha5a5, 4));
    directed.push_back(make_request(KIND_PUSH, 16'h0001, NUM_LVL));
    directed.push_back(make_request(KIND_PEEK, 16'h0000, NUM_LVL));
    directed.push_back(make_request(KIND_POP, 16'hffff, NUM_LVL));
    directed.push_back(make_request(KIND_POP, 16'h0000, 0));
    directed.push_back(make_request(KIND_POP, 16'h0000, 4));
    directed.push_back(make_request(KIND_UNUSED, 16'h0000, 1));
    directed.push_back(make_request(KIND_PEEK, 16'h0000, 15));
    directed.push_back(make_request(KIND_POP, 16'h0000, 1));
    directed.push_back(make_request(KIND_POP, 16'h0000, 1));
    directed.push_back(make_request(KIND_PEEK, 16'h0000, 1));
    foreach (directed[i]) send_request(directed[i], (i % 3 == 0) ? 1 : 0);
    wait_drained();

    run_phase(150, 80, 10, 1, NUM_LVL, 1'b1);
    run_phase(60, 85, 5, 3, 3, 1'b1);
    run_phase(150, 45, 40, 1, NUM_LVL, 1'b0);
    run_phase(150, 15, 70, 1, NUM_LVL, 1'b1);
    run_phase(150, 90, 5, 1, NUM_LVL, 1'b1);
    run_phase(80, 5, 85, 1, NUM_LVL, 1'b1);

    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.owed_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
